>>> hw/rtl/julian_to_gregorian_date_assert.svh
// Assertion macros shared by the Julian date converter RTL.
`ifndef JULIAN_TO_GREGORIAN_DATE_ASSERT_SVH
`define JULIAN_TO_GREGORIAN_DATE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define JTG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define JTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jtg_pkg.sv
// Types and constants for the Julian day to Gregorian date converter.
package jtg_pkg;

    // Pipeline: input reg, prep, five work stages, result reg.
    localparam int STAGES = 8;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    localparam logic [22:0] JD_LOW      = 23'd1721120;
    localparam logic [22:0] JD_HIGH     = 23'd5373484;
    localparam logic [22:0] JD_EPOCH    = 23'd1721119;
    localparam logic [26:0] DAY_MS      = 27'd86400000;
    localparam logic [26:0] HALF_DAY_MS = 27'd43200000;
    localparam logic [21:0] HOUR_MS     = 22'd3600000;
    localparam logic [15:0] MINUTE_MS   = 16'd60000;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [10:0] QUAD_DAYS   = 11'd1461;
    localparam logic [7:0]  MONTH_SPAN  = 8'd153;

    // Reciprocals m = ceil(2^s / d), s = dividend bits + divisor bits: exact floor.
    localparam int ERA_SHIFT  = 42;
    localparam logic [24:0] ERA_RECIP =
        25'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);
    localparam int WEEK_SHIFT = 26;
    localparam logic [23:0] WEEK_RECIP =
        24'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
    localparam int HOUR_SHIFT = 49;
    localparam logic [27:0] HOUR_RECIP =
        28'(((64'd1 << HOUR_SHIFT) + 64'd3599999) / 64'd3600000);
    localparam int QUAD_SHIFT = 29;
    localparam logic [18:0] QUAD_RECIP =
        19'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);
    localparam int MIN_SHIFT  = 38;
    localparam logic [22:0] MIN_RECIP =
        23'(((64'd1 << MIN_SHIFT) + 64'd59999) / 64'd60000);
    // x / 5 for x < 1024
    localparam logic [15:0] FIFTH_RECIP = 16'd205;

    typedef struct packed {
        logic        oor;
        logic [23:0] x1;   // 4 * days since epoch - 1
        logic [22:0] wn;   // day count + 1, for weekday
        logic [26:0] msc;  // civil milliseconds since midnight
    } front_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
    } date_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_millis;
    } tod_t;

endpackage

>>> hw/rtl/jtg_front.sv
// Range check, half-day shift and operand prep for the converter.
module jtg_front (
    input  logic                clk,
    input  jtg_pkg::pipe_ctrl_t ctrl,
    input  logic [22:0]         julian_day,
    input  logic [26:0]         day_millis,
    output jtg_pkg::front_t     front
);
    import jtg_pkg::*;

    logic        oor;
    logic [26:0] ms_sat;
    logic        carry;
    logic [22:0] jd_civil;
    logic [22:0] days;
    front_t      front_next;
    front_t      front_reg;

    assign oor      = (julian_day < JD_LOW) || (julian_day > JD_HIGH);
    assign ms_sat   = (day_millis >= DAY_MS) ? (DAY_MS - 27'd1) : day_millis;
    assign carry    = (ms_sat >= HALF_DAY_MS);
    assign jd_civil = julian_day + {22'd0, carry};
    assign days     = jd_civil - JD_EPOCH;

    always_comb
    begin
        front_next.oor = oor;
        front_next.x1  = {days[21:0], 2'b00} - 24'd1;
        front_next.wn  = jd_civil + 23'd1;
        front_next.msc = carry ? (ms_sat - HALF_DAY_MS) : (ms_sat + HALF_DAY_MS);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

>>> hw/rtl/jtg_date.sv
// Calendar split of the civil day count into year, month, day and weekday.
module jtg_date (
    input  logic                clk,
    input  jtg_pkg::pipe_ctrl_t ctrl,
    input  jtg_pkg::front_t     front,
    output jtg_pkg::date_t      date_next
);
    import jtg_pkg::*;

    // stage 2: reciprocal products
    logic [48:0] pc_reg;
    logic [46:0] pw_reg;
    logic [23:0] x1_2_reg;
    logic [22:0] wn_2_reg;
    // stage 3: century and weekday
    logic [6:0]  c_3_reg;
    logic [17:0] x2_3_reg;
    logic [2:0]  wd_3_reg;
    // stage 4: year-in-century product
    logic [36:0] pq_4_reg;
    logic [17:0] x2_4_reg;
    logic [6:0]  c_4_reg;
    logic [2:0]  wd_4_reg;
    // stage 5: day of year
    logic [6:0]  q_5_reg;
    logic [10:0] x3_5_reg;
    logic [6:0]  c_5_reg;
    logic [2:0]  wd_5_reg;
    // stage 6: raw month
    logic [3:0]  mo_6_reg;
    logic [10:0] x3_6_reg;
    logic [6:0]  q_6_reg;
    logic [6:0]  c_6_reg;
    logic [2:0]  wd_6_reg;

    logic [6:0]  c_w;
    logic [23:0] t2_w;
    logic [19:0] wq_w;
    logic [22:0] wrem_w;
    logic [6:0]  q_w;
    logic [17:0] d2_w;
    logic [8:0]  dy_w;
    logic [10:0] x3_w;
    logic [3:0]  mo_w;
    logic [10:0] dd_w;
    logic [15:0] dq_w;
    logic [13:0] yr_w;

    assign c_w    = pc_reg[ERA_SHIFT+6:ERA_SHIFT];
    assign t2_w   = x1_2_reg - 24'(c_w) * 24'(ERA_DAYS);
    assign wq_w   = pw_reg[WEEK_SHIFT+19:WEEK_SHIFT];
    assign wrem_w = wn_2_reg - 23'(wq_w) * 23'd7;

    assign q_w  = pq_4_reg[QUAD_SHIFT+6:QUAD_SHIFT];
    assign d2_w = x2_4_reg - 18'(q_w) * 18'(QUAD_DAYS);
    assign dy_w = 9'(d2_w[10:2]) + 9'd1;
    assign x3_w = 11'(dy_w) * 11'd5 - 11'd3;

    // month index: how many 153-step spans (x3 counts fifths of a day) fit below x3 (at most eleven)
    always_comb
    begin
        mo_w = 4'd0;
        for (int k = 1; k <= 11; k++)
        begin
            if (x3_5_reg >= 11'(MONTH_SPAN * k))
            begin
                mo_w = mo_w + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            pc_reg   <= 49'(front.x1) * 49'(ERA_RECIP);
            pw_reg   <= 47'(front.wn) * 47'(WEEK_RECIP);
            x1_2_reg <= front.x1;
            wn_2_reg <= front.wn;
        end
        if (ctrl.load[3])
        begin
            c_3_reg  <= c_w;
            x2_3_reg <= {t2_w[17:2], 2'b11};
            wd_3_reg <= wrem_w[2:0];
        end
        if (ctrl.load[4])
        begin
            pq_4_reg <= 37'(x2_3_reg) * 37'(QUAD_RECIP);
            x2_4_reg <= x2_3_reg;
            c_4_reg  <= c_3_reg;
            wd_4_reg <= wd_3_reg;
        end
        if (ctrl.load[5])
        begin
            q_5_reg  <= q_w;
            x3_5_reg <= x3_w;
            c_5_reg  <= c_4_reg;
            wd_5_reg <= wd_4_reg;
        end
        if (ctrl.load[6])
        begin
            mo_6_reg <= mo_w;
            x3_6_reg <= x3_5_reg;
            q_6_reg  <= q_5_reg;
            c_6_reg  <= c_5_reg;
            wd_6_reg <= wd_5_reg;
        end
    end

    // day = (x3 mod 153) / 5 + 1; months from March, Jan/Feb roll the year
    assign dd_w = x3_6_reg - 11'(MONTH_SPAN) * 11'(mo_6_reg);
    assign dq_w = 16'(dd_w[7:0]) * FIFTH_RECIP;
    assign yr_w = 14'(c_6_reg) * 14'd100 + 14'(q_6_reg);

    always_comb
    begin
        date_next.day_of_month = 5'(dq_w[14:10]) + 5'd1;
        date_next.weekday      = wd_6_reg;
        if (mo_6_reg < 4'd10)
        begin
            date_next.month = mo_6_reg + 4'd3;
            date_next.year  = yr_w;
        end
        else
        begin
            date_next.month = mo_6_reg - 4'd9;
            date_next.year  = yr_w + 14'd1;
        end
    end

endmodule

>>> hw/rtl/jtg_tod.sv
// Time-of-day split of civil milliseconds into hour, minute and millis.
module jtg_tod (
    input  logic                clk,
    input  jtg_pkg::pipe_ctrl_t ctrl,
    input  jtg_pkg::front_t     front,
    output jtg_pkg::tod_t       tod_next
);
    import jtg_pkg::*;

    logic [54:0] ph_2_reg;
    logic [26:0] msc_2_reg;
    logic [4:0]  hr_3_reg;
    logic [21:0] remh_3_reg;
    logic [44:0] pm_4_reg;
    logic [21:0] remh_4_reg;
    logic [4:0]  hr_4_reg;
    logic [4:0]  hr_5_reg;
    logic [5:0]  mi_5_reg;
    logic [15:0] sm_5_reg;
    logic [4:0]  hr_6_reg;
    logic [5:0]  mi_6_reg;
    logic [15:0] sm_6_reg;

    logic [4:0]  hr_w;
    logic [26:0] remh_w;
    logic [5:0]  mi_w;
    logic [21:0] sm_w;

    assign hr_w   = ph_2_reg[HOUR_SHIFT+4:HOUR_SHIFT];
    assign remh_w = msc_2_reg - 27'(hr_w) * 27'(HOUR_MS);
    assign mi_w   = pm_4_reg[MIN_SHIFT+5:MIN_SHIFT];
    assign sm_w   = remh_4_reg - 22'(mi_w) * 22'(MINUTE_MS);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            ph_2_reg  <= 55'(front.msc) * 55'(HOUR_RECIP);
            msc_2_reg <= front.msc;
        end
        if (ctrl.load[3])
        begin
            hr_3_reg   <= hr_w;
            remh_3_reg <= remh_w[21:0];
        end
        if (ctrl.load[4])
        begin
            pm_4_reg   <= 45'(remh_3_reg) * 45'(MIN_RECIP);
            remh_4_reg <= remh_3_reg;
            hr_4_reg   <= hr_3_reg;
        end
        if (ctrl.load[5])
        begin
            hr_5_reg <= hr_4_reg;
            mi_5_reg <= mi_w;
            sm_5_reg <= sm_w[15:0];
        end
        if (ctrl.load[6])
        begin
            hr_6_reg <= hr_5_reg;
            mi_6_reg <= mi_5_reg;
            sm_6_reg <= sm_5_reg;
        end
    end

    always_comb
    begin
        tod_next.hour          = hr_6_reg;
        tod_next.minute        = mi_6_reg;
        tod_next.second_millis = sm_6_reg;
    end

endmodule

>>> hw/rtl/julian_to_gregorian_date.sv
// Julian day plus noon-based milliseconds to Gregorian date, weekday and time.
// Path: an accepted request passes eight registers (input, prep, five work stages,
//   result) on its way to result valid, held up only while the output is stalled.
// Throughput: one request per cycle while the output is not stalled; each stage holds only while the one after
//   it is full and stalled, so bubbles close up and no slot is lost.
// Reset: rst_n async, active low, empties every stage; payload is not reset.
`include "julian_to_gregorian_date_assert.svh"

module julian_to_gregorian_date (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // [22:0] julian_day, [49:23] day_millis, [55:50] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [13:0] year, [17:14] month, [22:18] day_of_month,
                                       // [25:23] weekday, [30:26] hour, [36:31] minute,
                                       // [52:37] second_millis, [55:53] zero
    output logic        m_axis_tuser   // out_of_range
);
    import jtg_pkg::*;

    // Per-stage occupancy; stage 0 is the input register, stage 7 the result.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_ready;
    pipe_ctrl_t        ctrl;

    logic [22:0] julian_day_reg;
    logic [26:0] day_millis_reg;
    logic [6:2]  oor_reg;          // out-of-range flag riding along stages 2..6

    front_t      front;
    date_t       date_next;
    tod_t        tod_next;

    logic [55:0] tdata_next;
    logic [55:0] tdata_reg;
    logic        oor_out_reg;

    // A stage can take new data when empty or when its contents move on.
    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_ready[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign ctrl.load = stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Input register: fields as they come in on the request.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            julian_day_reg <= s_axis_tdata[22:0];
            day_millis_reg <= s_axis_tdata[49:23];
        end
    end

    // Half-day shift, saturation and window check.
    jtg_front u_front (
        .clk        (clk),
        .ctrl       (ctrl),
        .julian_day (julian_day_reg),
        .day_millis (day_millis_reg),
        .front      (front)
    );

    // Calendar path: century, year in century, month, day, weekday.
    jtg_date u_date (
        .clk       (clk),
        .ctrl      (ctrl),
        .front     (front),
        .date_next (date_next)
    );

    // Time path: hour, minute, milliseconds within the minute.
    jtg_tod u_tod (
        .clk      (clk),
        .ctrl     (ctrl),
        .front    (front),
        .tod_next (tod_next)
    );

    // The window flag runs beside the arithmetic so it lines up at the end.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            oor_reg[2] <= front.oor;
        end
        for (int k = 3; k <= 6; k++)
        begin
            if (ctrl.load[k])
            begin
                oor_reg[k] <= oor_reg[k-1];
            end
        end
    end

    // Out of window: every field zero, only the flag set.
    always_comb
    begin
        if (oor_reg[6])
        begin
            tdata_next = '0;
        end
        else
        begin
            tdata_next = {3'd0,
                          tod_next.second_millis,
                          tod_next.minute,
                          tod_next.hour,
                          date_next.weekday,
                          date_next.day_of_month,
                          date_next.month,
                          date_next.year};
        end
    end

    // Result register; holds the result steady while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[7])
        begin
            tdata_reg   <= tdata_next;
            oor_out_reg <= oor_reg[6];
        end
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = oor_out_reg;

    `JTG_ASSERT_IMPLIES(a_oor_zeroes_fields, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == 56'd0, "out-of-range result carries nonzero fields")
    `JTG_ASSERT_IMPLIES(a_date_fields_legal, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[17:14] >= 4'd1 && m_axis_tdata[17:14] <= 4'd12
            && m_axis_tdata[22:18] >= 5'd1 && m_axis_tdata[25:23] <= 3'd6,
        "date fields outside legal range")
    `JTG_ASSERT_IMPLIES(a_time_fields_legal, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[30:26] <= 5'd23 && m_axis_tdata[36:31] <= 6'd59
            && m_axis_tdata[52:37] <= 16'd59999,
        "time fields outside legal range")
    `JTG_ASSERT_NEXT(a_pipe_refills_output, m_axis_tvalid && m_axis_tready && valid_reg[6],
        m_axis_tvalid, "result taken but next full stage did not advance")

endmodule

>>> dv/julian_to_gregorian_date_checker.sv
`timescale 1ns / 100ps
// Stream checker for the Julian day converter: predicts each date and compares results.
module julian_to_gregorian_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          error_count,
    output int          open_count,
    output int          result_count,
    output int          oor_count
);
    import jtg_pkg::*;

    typedef struct packed {
        logic  out_of_range;
        date_t date;
        tod_t  tod;
    } civil_stamp_t;

    civil_stamp_t pending_dates[$];
    int           mismatches = 0;
    int           dates_seen = 0;
    int           oor_seen   = 0;

    // Noon-based Julian day plus milliseconds -> civil date, weekday and time of day.
    function automatic civil_stamp_t civil_from_julian(logic [22:0] jd_in, logic [26:0] ms_in);
        civil_stamp_t    stamp;
        longint unsigned day;
        longint unsigned ms;
        longint unsigned t;
        longint unsigned era;
        longint unsigned quad;
        longint unsigned dd;
        longint unsigned mm;
        longint unsigned yy;
        longint unsigned hr;
        longint unsigned mi;
        stamp = '0;
        if (jd_in < JD_LOW || jd_in > JD_HIGH)
        begin
            stamp.out_of_range = 1'b1;
            return stamp;
        end
        day = 64'(jd_in);
        ms  = 64'(ms_in);
        if (ms >= DAY_MS)
            ms = DAY_MS - 1;
        // fraction past noon rolls the civil date once it reaches midnight
        if (ms >= HALF_DAY_MS)
        begin
            ms  = ms - HALF_DAY_MS;
            day = day + 1;
        end
        else
            ms = ms + HALF_DAY_MS;
        stamp.date.weekday = 3'((day + 1) % 7);

        t    = day - JD_EPOCH;
        era  = (4 * t - 1) / ERA_DAYS;
        t    = 4 * t - 1 - ERA_DAYS * era;
        dd   = t / 4;
        quad = (4 * dd + 3) / QUAD_DAYS;
        dd   = 4 * dd + 3 - QUAD_DAYS * quad;
        dd   = (dd + 4) / 4;
        mm   = (5 * dd - 3) / MONTH_SPAN;
        dd   = 5 * dd - 3 - MONTH_SPAN * mm;
        dd   = (dd + 5) / 5;
        yy   = 100 * era + quad;
        // year runs March to February
        if (mm < 10)
            mm = mm + 3;
        else
        begin
            mm = mm - 9;
            yy = yy + 1;
        end

        hr = ms / HOUR_MS;
        ms = ms - hr * HOUR_MS;
        mi = ms / MINUTE_MS;
        stamp.date.year          = 14'(yy);
        stamp.date.month         = 4'(mm);
        stamp.date.day_of_month  = 5'(dd);
        stamp.tod.hour           = 5'(hr);
        stamp.tod.minute         = 6'(mi);
        stamp.tod.second_millis  = 16'(ms - mi * MINUTE_MS);
        return stamp;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_streams
        civil_stamp_t want;
        // retire first so a same-edge request never matches itself
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result with no request outstanding: tdata=%h tuser=%b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                compare_field("year",          want.date.year,         m_axis_tdata[13:0]);
                compare_field("month",         want.date.month,        m_axis_tdata[17:14]);
                compare_field("day_of_month",  want.date.day_of_month, m_axis_tdata[22:18]);
                compare_field("weekday",       want.date.weekday,      m_axis_tdata[25:23]);
                compare_field("hour",          want.tod.hour,          m_axis_tdata[30:26]);
                compare_field("minute",        want.tod.minute,        m_axis_tdata[36:31]);
                compare_field("second_millis", want.tod.second_millis, m_axis_tdata[52:37]);
                compare_field("out_of_range",  want.out_of_range,      m_axis_tuser);
                if (want.out_of_range)
                    oor_seen++;
            end
            dates_seen++;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_dates.push_back(civil_from_julian(s_axis_tdata[22:0], s_axis_tdata[49:23]));
        error_count  <= mismatches;
        open_count   <= pending_dates.size();
        result_count <= dates_seen;
        oor_count    <= oor_seen;
    end

endmodule

>>> dv/julian_to_gregorian_date_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Julian day to Gregorian date converter.
module julian_to_gregorian_date_tb;
    import jtg_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 80;   // long output stall, fills all 8 stages
    localparam int DRAIN_CYCLES   = 16;   // time through the pipeline plus margin
    localparam int PHASE_REQUESTS = 205;
    localparam int BURST_REQUESTS = 40;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // [22:0] julian_day, [49:23] day_millis, [55:50] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // [13:0] year, [17:14] month, [22:18] day_of_month,
                                       // [25:23] weekday, [30:26] hour, [36:31] minute,
                                       // [52:37] second_millis, [55:53] zero
    logic        m_axis_tuser;         // out_of_range

    int error_count;
    int open_count;
    int result_count;
    int oor_count;

    int tx_idle_pct = 0;   // chance per cycle that the sender holds back a request
    int rx_idle_pct = 0;   // chance per cycle that the receiver drops tready
    int hold_seq    = 0;   // bumped by stimulus to ask the receiver for a long stall
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    julian_to_gregorian_date dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    julian_to_gregorian_date_checker date_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .open_count    (open_count),
        .result_count  (result_count),
        .oor_count     (oor_count)
    );

    // Result side: random back-pressure, or a counted hard stall on request.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offer one request, with random idle cycles ahead of it, and wait for accept.
    // tvalid stays high on return; the next call or drain_results decides its fate.
    task automatic send_timestamp(logic [22:0] jd, logic [26:0] ms);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ms, jd};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Mostly dates inside the window, some at its edges, some anywhere in 23 bits.
    // Fraction is mostly legal, often near the noon/midnight split, sometimes oversized.
    task automatic send_random_timestamp();
        logic [22:0] jd;
        logic [26:0] ms;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 75)
            jd = 23'($urandom_range(JD_HIGH, JD_LOW));
        else if (pick < 85)
            jd = pick[0] ? 23'(JD_LOW - 2 + $urandom_range(4))
                         : 23'(JD_HIGH - 2 + $urandom_range(4));
        else
            jd = 23'($urandom_range(23'h7FFFFF, 0));
        pick = $urandom_range(99);
        if (pick < 80)
            ms = 27'($urandom_range(DAY_MS - 1, 0));
        else if (pick < 92)
            ms = 27'(HALF_DAY_MS - 2 + $urandom_range(3));
        else
            ms = 27'($urandom_range(27'h7FFFFFF, DAY_MS));
        send_timestamp(jd, ms);
    endtask

    // Stop offering and wait until every outstanding request has its result.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (open_count != 0);
    endtask

    initial
    begin : stimulus
        int tx_pcts [3];
        int rx_pcts [3];
        tx_pcts = '{17, 72, 0};
        rx_pcts = '{72, 17, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = tx_pcts[0];
        rx_idle_pct = rx_pcts[0];

        // Directed: window edges, field extremes, noon split, saturation, leap days.
        send_timestamp(23'd0, 27'd0);
        send_timestamp(JD_LOW - 23'd1, 27'd0);            // just below the window
        send_timestamp(JD_LOW, 27'd0);                    // first supported day
        send_timestamp(JD_LOW, HALF_DAY_MS - 27'd1);      // last ms before midnight
        send_timestamp(JD_LOW, HALF_DAY_MS);              // carries to next civil day
        send_timestamp(JD_HIGH, 27'd0);
        send_timestamp(JD_HIGH, DAY_MS - 27'd1);          // carry past the last day
        send_timestamp(JD_HIGH + 23'd1, HALF_DAY_MS);     // just above the window
        send_timestamp(23'h7FFFFF, 27'h7FFFFFF);          // all ones, out of window
        send_timestamp(23'd2451545, DAY_MS);              // fraction saturates
        send_timestamp(23'd2451545, 27'h7FFFFFF);         // largest fraction saturates
        send_timestamp(23'd2451544, HALF_DAY_MS - 27'd1); // Dec 31 late evening
        send_timestamp(23'd2451544, DAY_MS - 27'd1);      // rolls into Jan 1
        send_timestamp(23'd2451603, HALF_DAY_MS);         // Feb 29 in a century leap year
        send_timestamp(23'd2451604, HALF_DAY_MS);         // Mar 1 after it
        send_timestamp(23'd2415078, HALF_DAY_MS);         // Feb 28 in a non-leap century
        send_timestamp(23'd2415079, HALF_DAY_MS);         // straight to Mar 1
        send_timestamp(23'd2460000, 27'd3599999);         // hour/minute boundaries
        send_timestamp(23'd2460000, 27'd46859999);
        drain_results();                                  // sender waits for every result

        // Back-pressure burst: output held off while the sender keeps pushing,
        // so the pipe fills up and tready falls.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_seq++;
        repeat (BURST_REQUESTS) send_random_timestamp();
        drain_results();

        // Random pacing phases: slow receiver, slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = tx_pcts[phase];
            rx_idle_pct = rx_pcts[phase];
            repeat (PHASE_REQUESTS) send_random_timestamp();
        end
        drain_results();
        rx_idle_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps, %0d of them outside the day window,",
                 result_count, oor_count);
        $display("under three pacing mixes and one long output stall.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
